// ----- hdl/uvbif_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package uvbif_pkg;

  // descriptor codes and limits
  localparam logic [7:0]  IFACE_TYPE    = 8'd4;
  localparam logic [7:0]  IFACE_MIN_LEN = 8'd9;
  localparam logic [7:0]  EP_TYPE       = 8'd5;
  localparam logic [7:0]  EP_MIN_LEN    = 8'd7;
  localparam logic [7:0]  MIN_DESC_LEN  = 8'd2;
  localparam logic [7:0]  VENDOR_CLASS  = 8'hff;
  localparam logic [1:0]  XFER_BULK     = 2'd2;
  localparam int unsigned DIR_IN_BIT    = 7;
  localparam int unsigned MPS_WIDTH     = 11;

  // byte position codes inside a descriptor
  localparam logic [7:0] POS_LENGTH = 8'd0;
  localparam logic [7:0] POS_TYPE   = 8'd1;
  localparam logic [7:0] POS_TWO    = 8'd2;
  localparam logic [7:0] POS_THREE  = 8'd3;
  localparam logic [7:0] POS_FOUR   = 8'd4;
  localparam logic [7:0] POS_FIVE   = 8'd5;

  typedef struct packed {
    logic [7:0] desc_byte;
    logic       last_byte;
  } uvbif_in_t;

  typedef struct packed {
    logic                 found;
    logic [7:0]           interface_number;
    logic [7:0]           bulk_in_address;
    logic [7:0]           bulk_out_address;
    logic [MPS_WIDTH-1:0] out_max_packet;
  } uvbif_out_t;

endpackage

`default_nettype wire

// ----- hdl/uvbif_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module uvbif_parser (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   advance,
  input  uvbif_pkg::uvbif_in_t  byte_data,
  output uvbif_pkg::uvbif_out_t result
);
  import uvbif_pkg::*;

  logic [7:0]           pos_in_desc, pos_in_desc_next;
  logic [7:0]           cur_desc_len, cur_desc_len_next;
  logic [7:0]           cur_desc_type, cur_desc_type_next;
  logic [7:0]           byte_two, byte_two_next;
  logic [7:0]           byte_three, byte_three_next;
  logic [7:0]           byte_four, byte_four_next;
  logic [7:0]           byte_five, byte_five_next;
  logic [7:0]           current_iface, current_iface_next;
  logic                 vendor_seen, vendor_seen_next;
  logic [7:0]           in_ep, in_ep_next;
  logic [7:0]           out_ep, out_ep_next;
  logic [MPS_WIDTH-1:0] out_mps_reg, out_mps_reg_next;
  logic                 halted, halted_next;
  logic                 desc_done;
  logic                 have_match;
  logic                 match_next;
  logic [7:0]           b;

  assign b          = byte_data.desc_byte;
  assign have_match = vendor_seen && (in_ep != 8'd0) && (out_ep != 8'd0);
  assign desc_done  = ({1'b0, pos_in_desc} + 9'd1) >= {1'b0, cur_desc_len};

  // per-byte descriptor update
  always_comb begin
    pos_in_desc_next   = pos_in_desc;
    cur_desc_len_next  = cur_desc_len;
    cur_desc_type_next = cur_desc_type;
    byte_two_next      = byte_two;
    byte_three_next    = byte_three;
    byte_four_next     = byte_four;
    byte_five_next     = byte_five;
    current_iface_next = current_iface;
    vendor_seen_next   = vendor_seen;
    in_ep_next         = in_ep;
    out_ep_next        = out_ep;
    out_mps_reg_next   = out_mps_reg;
    halted_next        = halted;
    if (!halted) begin
      if (pos_in_desc == POS_LENGTH) begin
        cur_desc_len_next = b;
        if (b < MIN_DESC_LEN) begin
          halted_next = 1'b1;
        end else begin
          pos_in_desc_next = POS_TYPE;
        end
      end else begin
        case (pos_in_desc)
          POS_TYPE:  cur_desc_type_next = b;
          POS_TWO:   byte_two_next      = b;
          POS_THREE: byte_three_next    = b;
          POS_FOUR:  byte_four_next     = b;
          POS_FIVE:  byte_five_next     = b;
          default:   ;
        endcase
        if (desc_done) begin
          pos_in_desc_next = POS_LENGTH;
          // act on the completed descriptor
          if (cur_desc_type_next == IFACE_TYPE && cur_desc_len >= IFACE_MIN_LEN) begin
            if (have_match) begin
              halted_next = 1'b1;
            end else begin
              current_iface_next = byte_two_next;
              vendor_seen_next   = (byte_five_next == VENDOR_CLASS);
              in_ep_next         = 8'd0;
              out_ep_next        = 8'd0;
              out_mps_reg_next   = '0;
            end
          end else if (cur_desc_type_next == EP_TYPE && cur_desc_len >= EP_MIN_LEN &&
                       vendor_seen) begin
            if (byte_three_next[1:0] == XFER_BULK) begin
              if (byte_two_next[DIR_IN_BIT]) begin
                in_ep_next = byte_two_next;
              end else begin
                out_ep_next      = byte_two_next;
                out_mps_reg_next = {byte_five_next[MPS_WIDTH-9:0], byte_four_next};
              end
            end
          end
        end else begin
          pos_in_desc_next = pos_in_desc + 8'd1;
        end
      end
    end
  end

  // result for the set as it stands after this byte
  assign match_next = vendor_seen_next && (in_ep_next != 8'd0) && (out_ep_next != 8'd0);

  always_comb begin
    result = '0;
    if (match_next) begin
      result.found            = 1'b1;
      result.interface_number = current_iface_next;
      result.bulk_in_address  = in_ep_next;
      result.bulk_out_address = out_ep_next;
      result.out_max_packet   = out_mps_reg_next;
    end
  end

  // parser state, cleared by rst and after the last byte of a set
  always_ff @(posedge clk) begin
    if (rst || (advance && byte_data.last_byte)) begin
      pos_in_desc   <= '0;
      cur_desc_len  <= '0;
      cur_desc_type <= '0;
      byte_two      <= '0;
      byte_three    <= '0;
      byte_four     <= '0;
      byte_five     <= '0;
      current_iface <= '0;
      vendor_seen   <= 1'b0;
      in_ep         <= '0;
      out_ep        <= '0;
      out_mps_reg   <= '0;
      halted        <= 1'b0;
    end else if (advance) begin
      pos_in_desc   <= pos_in_desc_next;
      cur_desc_len  <= cur_desc_len_next;
      cur_desc_type <= cur_desc_type_next;
      byte_two      <= byte_two_next;
      byte_three    <= byte_three_next;
      byte_four     <= byte_four_next;
      byte_five     <= byte_five_next;
      current_iface <= current_iface_next;
      vendor_seen   <= vendor_seen_next;
      in_ep         <= in_ep_next;
      out_ep        <= out_ep_next;
      out_mps_reg   <= out_mps_reg_next;
      halted        <= halted_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/usb_vendor_bulk_interface_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   valid          ready          payload
// bytes     byte_valid     byte_ready     byte_data   (desc_byte, last_byte)
// results   result_valid   result_ready   result_data (found, interface_number,
//                                                      bulk_in_address, bulk_out_address,
//                                                      out_max_packet)
//
// one byte per cycle unless a byte that ends a set is held; each byte is registered
// in the input register, and the parser updates its state and the result register
// as the byte leaves it; a result is loaded when the last byte of its set leaves.
// rst clears the input register, the parser state and the result register.
// while a result waits, bytes that do not end a set still flow; a byte that
// ends a set waits in the input register until the result register is free.

module usb_vendor_bulk_interface_finder (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   byte_valid,
  output logic                  byte_ready,
  input  uvbif_pkg::uvbif_in_t  byte_data,
  output logic                  result_valid,
  input  wire                   result_ready,
  output uvbif_pkg::uvbif_out_t result_data
);
  import uvbif_pkg::*;

  uvbif_in_t  s1_data;
  logic       s1_valid;
  logic       s1_move;
  logic       result_load;
  uvbif_out_t parsed;

  // input stage can hand its byte on unless it ends a set and the result is blocked
  assign s1_move     = s1_valid && (!s1_data.last_byte || !result_valid || result_ready);
  assign byte_ready  = !s1_valid || s1_move;
  assign result_load = s1_move && s1_data.last_byte;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      s1_data <= byte_data;
    end
  end

  uvbif_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (s1_move),
    .byte_data (s1_data),
    .result    (parsed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result_data <= parsed;
    end
  end

  // checks
  a_empty_when_not_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.found |->
      result_data.interface_number == 8'd0 && result_data.bulk_in_address == 8'd0 &&
      result_data.bulk_out_address == 8'd0 && result_data.out_max_packet == '0)
    else $error("result fields not cleared when nothing found");

  a_found_endpoints: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.found |->
      result_data.bulk_in_address[DIR_IN_BIT] && result_data.bulk_out_address != 8'd0)
    else $error("found result without valid in and out endpoints");

  a_last_byte_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_data.last_byte |=> result_valid)
    else $error("last byte did not load a result");

  a_blocked_last_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_data.last_byte && result_valid && !result_ready |-> !byte_ready)
    else $error("input taken while a set end is blocked");

endmodule

`default_nettype wire
